// ===== rtl/tcrrsq_pkg.sv =====
package tcrrsq_pkg;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVE   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_BAD_DEPT = 3'd1,
    ST_FULL     = 3'd2,
    ST_SERVED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_DEPTS = 3'd0,
    CFG_AGE   = 3'd1,
    CFG_ATT0  = 3'd2,
    CFG_ATT1  = 3'd3,
    CFG_ATT2  = 3'd4,
    CFG_ATT3  = 3'd5
  } cfg_idx_t;

  localparam int unsigned NUM_ATT = 4;
  localparam logic [2:0] DEPTS_RESET = 3'd4;
  localparam logic [7:0] AGE_RESET   = 8'd60;
  localparam logic [3:0] ATT_RESET   = 4'd1;

  typedef struct packed {
    logic [2:0]              dept_count;
    logic [7:0]              age_threshold;
    logic [NUM_ATT-1:0][3:0] attendants;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] dept;
    logic       prio;
    logic       turn_end;
  } res_t;

endpackage

// ===== rtl/tcrrsq_cfg.sv =====
module tcrrsq_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [7:0]        wr_data,
  output tcrrsq_pkg::cfg_t  cfg
);
  import tcrrsq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_DEPTS: cfg_nxt.dept_count    = wr_data[2:0];
        CFG_AGE:   cfg_nxt.age_threshold = wr_data;
        CFG_ATT0:  cfg_nxt.attendants[0] = wr_data[3:0];
        CFG_ATT1:  cfg_nxt.attendants[1] = wr_data[3:0];
        CFG_ATT2:  cfg_nxt.attendants[2] = wr_data[3:0];
        CFG_ATT3:  cfg_nxt.attendants[3] = wr_data[3:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dept_count    <= DEPTS_RESET;
      cfg_r.age_threshold <= AGE_RESET;
      cfg_r.attendants    <= {NUM_ATT{ATT_RESET}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/tcrrsq_store.sv =====
module tcrrsq_store #(
  parameter int unsigned WORDS     = 128,
  parameter int unsigned AW        = 7,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic                 re,
  input  logic [AW-1:0]        addr,
  input  logic [TAG_WIDTH-1:0] wdata,
  output logic [TAG_WIDTH-1:0] rdata
);

  logic [TAG_WIDTH-1:0] mem [WORDS];
  logic [TAG_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tcrrsq_sched.sv =====
module tcrrsq_sched #(
  parameter int unsigned NUM_DEPTS   = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned AW          = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  tcrrsq_pkg::op_t   op,
  input  logic [2:0]        dept,
  input  logic [7:0]        age,
  input  tcrrsq_pkg::cfg_t  cfg,
  output tcrrsq_pkg::res_t  res,
  output logic              mem_we,
  output logic              mem_re,
  output logic [AW-1:0]     mem_addr
);
  import tcrrsq_pkg::*;

  localparam int unsigned DW = (NUM_DEPTS > 1) ? $clog2(NUM_DEPTS) : 1;
  localparam int unsigned QW = DW + 1;
  localparam int unsigned NQ = NUM_DEPTS * 2;
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  logic [PW-1:0] head_r [NQ];
  logic [PW-1:0] tail_r [NQ];
  logic [FW-1:0] cnt_r  [NQ];
  logic [DW-1:0] cur_r;
  logic [3:0]    served_r;
  logic [DW-1:0] cur_nxt;
  logic [3:0]    served_nxt;

  logic [3:0]           n;
  logic [NUM_DEPTS-1:0] waiting;
  logic [DW-1:0]        cur_eff;
  logic [3:0]           served_eff;
  logic                 found;
  logic [DW-1:0]        sel;
  logic                 prio;
  logic                 dept_ok;
  logic [QW-1:0]        q_enq;
  logic [QW-1:0]        q_srv;
  logic [QW-1:0]        q;
  logic [FW-1:0]        cnt_q;
  logic [PW-1:0]        ptr;
  logic [PW-1:0]        ptr_inc;
  logic                 full;
  logic [3:0]           served_new;
  logic [3:0]           lim;
  logic                 left_after;
  logic                 turn_end;
  logic                 enq_ok;
  logic                 srv_go;
  logic                 is_serve;

  // effective department count
  always_comb begin
    if (cfg.dept_count == 3'd0) begin
      n = 4'd1;
    end else if (4'(cfg.dept_count) > 4'(NUM_DEPTS)) begin
      n = 4'(NUM_DEPTS);
    end else begin
      n = 4'(cfg.dept_count);
    end
  end

  always_comb begin
    for (int d = 0; d < NUM_DEPTS; d++) begin
      waiting[d] = (cnt_r[2*d] != '0) || (cnt_r[2*d+1] != '0);
    end
  end

  assign cur_eff    = (4'(cur_r) >= n) ? '0 : cur_r;
  assign served_eff = (4'(cur_r) >= n) ? 4'd0 : served_r;

  // round-robin scan from the current department
  always_comb begin
    logic [3:0] c_sum;
    found = 1'b0;
    sel   = cur_eff;
    c_sum = '0;
    for (int k = 0; k < NUM_DEPTS; k++) begin
      c_sum = 4'(cur_eff) + 4'(k);
      if (c_sum >= n) begin
        c_sum = c_sum - n;
      end
      if (!found && (4'(k) < n) && waiting[DW'(c_sum)]) begin
        found = 1'b1;
        sel   = DW'(c_sum);
      end
    end
  end

  assign is_serve = (op == OP_SERVE);
  assign dept_ok  = (4'(dept) < n);
  assign q_enq    = {dept[DW-1:0], (age < cfg.age_threshold)};
  assign prio     = (cnt_r[{sel, 1'b0}] != '0);
  assign q_srv    = {sel, !prio};
  assign q        = is_serve ? q_srv : q_enq;
  assign cnt_q    = cnt_r[q];
  assign ptr      = is_serve ? head_r[q] : tail_r[q];
  assign ptr_inc  = (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign full     = (cnt_q >= FW'(QUEUE_DEPTH));

  assign enq_ok = item_valid && !is_serve && dept_ok && !full;
  assign srv_go = item_valid && is_serve && found;

  // turn bookkeeping
  always_comb begin
    logic [2:0] sel3;
    sel3 = 3'(sel);
    if (sel3 < 3'(NUM_ATT)) begin
      lim = cfg.attendants[sel3[1:0]];
    end else begin
      lim = 4'd1;
    end
    if (lim == 4'd0) begin
      lim = 4'd1;
    end
  end

  assign served_new = ((sel != cur_eff) ? 4'd0 : served_eff) + 4'd1;
  assign left_after = (cnt_q != FW'(1)) || (prio && (cnt_r[{sel, 1'b1}] != '0));
  assign turn_end   = (served_new >= lim) || !left_after;

  always_comb begin
    cur_nxt    = cur_r;
    served_nxt = served_r;
    if (item_valid && is_serve) begin
      cur_nxt    = cur_eff;
      served_nxt = served_eff;
      if (found) begin
        if (turn_end) begin
          cur_nxt    = (4'(sel) + 4'd1 >= n) ? '0 : DW'(4'(sel) + 4'd1);
          served_nxt = 4'd0;
        end else begin
          cur_nxt    = sel;
          served_nxt = served_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      cur_r    <= '0;
      served_r <= '0;
    end else begin
      cur_r    <= cur_nxt;
      served_r <= served_nxt;
      if (enq_ok) begin
        tail_r[q] <= ptr_inc;
        cnt_r[q]  <= cnt_q + 1'b1;
      end
      if (srv_go) begin
        head_r[q] <= ptr_inc;
        cnt_r[q]  <= cnt_q - 1'b1;
      end
    end
  end

  always_comb begin
    res = '0;
    if (is_serve) begin
      if (found) begin
        res.status   = ST_SERVED;
        res.dept     = 2'(sel);
        res.prio     = prio;
        res.turn_end = turn_end;
      end else begin
        res.status = ST_EMPTY;
      end
    end else if (!dept_ok) begin
      res.status = ST_BAD_DEPT;
    end else if (full) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_ENQUEUED;
    end
  end

  assign mem_we   = enq_ok;
  assign mem_re   = srv_go;
  assign mem_addr = AW'(q) * AW'(QUEUE_DEPTH) + AW'(ptr);

  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store written and read in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (cnt_q != '0) && (4'(sel) < n))
    else $error("pop from an empty or inactive queue");

  a_turn_count: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && is_serve && found && !turn_end) |=> (served_r != 4'd0))
    else $error("open turn lost its served count");

endmodule

// ===== rtl/two_class_round_robin_service_queue_top.sv =====
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ---------------------------------------
// in_       in         start & !busy             operation, department, age, person_tag
// out_      out        out_strobe (one cycle)    status, served_department,
//                                                served_person, served_priority, turn_end
// cfg_      in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Each accepted word yields exactly one result word: it is held in the
// input register, then passes queue lookup and the store read into the
// result register. busy stays low, so a word may be started on every cycle;
// the single-port tag store handles the one push or pop per cycle.
// Reset (rst_n low, synchronous) empties every queue and restores the
// register defaults. The receiver cannot stall; results are never held.
module two_class_round_robin_service_queue_top #(
  parameter int unsigned NUM_DEPTS   = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_operation,
  input  logic [2:0]            in_department,
  input  logic [7:0]            in_age,
  input  logic [TAG_WIDTH-1:0]  in_person_tag,
  // result words
  output logic                  out_strobe,
  output logic [2:0]            out_status,
  output logic [1:0]            out_served_department,
  output logic [TAG_WIDTH-1:0]  out_served_person,
  output logic                  out_served_priority,
  output logic                  out_turn_end,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  import tcrrsq_pkg::*;

  localparam int unsigned DW    = (NUM_DEPTS > 1) ? $clog2(NUM_DEPTS) : 1;
  localparam int unsigned WORDS = NUM_DEPTS * 2 * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(WORDS);

  cfg_t cfg;
  res_t res;
  res_t res_r;

  // input register
  logic                 s1_valid_r;
  op_t                  s1_op_r;
  logic [2:0]           s1_dept_r;
  logic [7:0]           s1_age_r;
  logic [TAG_WIDTH-1:0] s1_tag_r;
  logic                 out_strobe_r;

  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [TAG_WIDTH-1:0] mem_rdata;

  logic                 accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  tcrrsq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // capture the word; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_op_r   <= op_t'(in_operation);
      s1_dept_r <= in_department;
      s1_age_r  <= in_age;
      s1_tag_r  <= in_person_tag;
    end
  end

  // pick the queue, advance its pointers and decide the status
  tcrrsq_sched #(
    .NUM_DEPTS   (NUM_DEPTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .op         (s1_op_r),
    .dept       (s1_dept_r),
    .age        (s1_age_r),
    .cfg        (cfg),
    .res        (res),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr)
  );

  // tag store: push writes at the tail, pop reads at the head into its output register
  tcrrsq_store #(
    .WORDS     (WORDS),
    .AW        (AW),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (s1_tag_r),
    .rdata (mem_rdata)
  );

  // result register, aligned with the store read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r;
    end
    if (s1_valid_r) begin
      res_r <= res;
    end
  end

  assign out_strobe            = out_strobe_r;
  assign out_status            = res_r.status;
  assign out_served_department = res_r.dept;
  assign out_served_priority   = res_r.prio;
  assign out_turn_end          = res_r.turn_end;
  // drop the stale read data unless this word served someone
  assign out_served_person     = (res_r.status == ST_SERVED) ? mem_rdata : '0;

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_strobe_r)
    else $error("accepted word produced no result");

  a_served_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (res_r.status == ST_SERVED)) |-> $past(mem_re))
    else $error("served result without a store read");

  a_dept_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (res_r.status == ST_SERVED)) |-> (3'(res_r.dept) < 3'(NUM_DEPTS)) ||
      (DW > 2))
    else $error("served department out of range");

endmodule
